[hdl/mvst_pkg.sv]
// ----------------------------------------------------------------------------
// Mixer volume shadow table package
// Shared types, operation codes and constants for the shadow table block.
// ----------------------------------------------------------------------------
package mvst_pkg;

   // Operation codes carried by the request item.
   localparam logic [2:0] OP_LOAD         = 3'd0;
   localparam logic [2:0] OP_WRITE_STEREO = 3'd1;
   localparam logic [2:0] OP_READ_STEREO  = 3'd2;
   localparam logic [2:0] OP_WRITE_MONO   = 3'd3;
   localparam logic [2:0] OP_READ_MONO    = 3'd4;
   localparam logic [2:0] OP_WRITE_MIC    = 3'd5;
   localparam logic [2:0] OP_READ_MIC     = 3'd6;
   localparam logic [2:0] OP_UNUSED       = 3'd7;

   // Level and register constants.
   localparam logic [6:0]  LEVEL_MAX      = 7'd100;
   localparam logic [6:0]  MIC_REG        = 7'h0E;
   localparam logic [15:0] MUTE_VALUE     = 16'h8000;
   localparam logic [15:0] MIC_MASK       = 16'h801F;
   localparam logic [15:0] MIC_FIELD_MASK = 16'h001F;
   localparam logic [15:0] BYTE_MASK      = 16'h00FF;

   // Floor division by 100 as a multiply by 5243 and a right shift by 19.
   // Exact for all dividends up to 12800, which covers 100 * 128.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam logic [4:0]  RECIP_SHIFT = 5'd19;

   // One stored table entry.
   typedef struct packed {
      logic [1:0]  codec;
      logic [6:0]  reg_addr;
      logic [2:0]  scale;
      logic        invert;
      logic [15:0] value;
   } mvst_entry_type;

   // Search item that walks down the row of cells.
   typedef struct packed {
      logic        active;
      logic [1:0]  codec;
      logic [6:0]  reg_addr;
      logic        hit;
      logic [2:0]  scale;
      logic        invert;
      logic [15:0] value;
   } mvst_token_type;

   // Result item payload.
   typedef struct packed {
      logic        found;
      logic [6:0]  left_percent;
      logic [6:0]  right_percent;
      logic        write_valid;
      logic [1:0]  write_codec;
      logic [6:0]  write_reg;
      logic [15:0] write_value;
      logic        table_full;
   } mvst_result_type;

endpackage

[hdl/mvst_ifs.sv]
// ----------------------------------------------------------------------------
// Mixer volume shadow table channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mvst_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [1:0]  codec;
   logic [6:0]  reg_addr;
   logic [6:0]  left_level;
   logic [6:0]  right_level;
   logic [2:0]  scale_bits;
   logic        invert_flag;
   logic [15:0] load_value;

   modport source (
      output valid, operation, codec, reg_addr, left_level, right_level,
             scale_bits, invert_flag, load_value,
      input  ready
   );
   modport sink (
      input  valid, operation, codec, reg_addr, left_level, right_level,
             scale_bits, invert_flag, load_value,
      output ready
   );
endinterface

interface mvst_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [6:0]  left_percent;
   logic [6:0]  right_percent;
   logic        write_valid;
   logic [1:0]  write_codec;
   logic [6:0]  write_reg;
   logic [15:0] write_value;
   logic        table_full;

   modport source (
      output valid, found, left_percent, right_percent, write_valid,
             write_codec, write_reg, write_value, table_full,
      input  ready
   );
   modport sink (
      input  valid, found, left_percent, right_percent, write_valid,
             write_codec, write_reg, write_value, table_full,
      output ready
   );
endinterface

[hdl/mixer_volume_shadow_table_top.sv]
// ----------------------------------------------------------------------------
// Mixer volume shadow table
// Shadow table of codec mixer registers that converts percent levels to
// attenuation fields and back, built as a row of entry cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Contents
//  req_chan  in         valid/ready    operation, codec, register, levels, load
//  rsp_chan  out        valid/ready    found, percents, codec write, table full
//
// A lookup's search item walks the row of cells one cell per cycle, then
// passes through the two-stage converter and the result register.
// Synchronous active-high reset clears the entry count and all handshake state.
// A stalled result stays in the output register while the next item is taken;
// that item then waits in the result holding register until the output frees.
// ----------------------------------------------------------------------------
module mixer_volume_shadow_table_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   mvst_req_if.sink   req_chan,
   mvst_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CONV,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [2:0]                op_ff;
   logic [6:0]                left_ff;
   logic [6:0]                right_ff;
   mvst_pkg::mvst_result_type res_ff;
   mvst_pkg::mvst_result_type rsp_ff;
   logic                      rsp_valid_ff;

   logic                      accept;
   logic                      is_load;
   logic                      is_lookup;
   logic                      is_mic;
   logic                      has_room;
   logic                      do_load;
   logic                      rsp_load;
   mvst_pkg::mvst_entry_type  load_entry;
   mvst_pkg::mvst_result_type load_res;
   mvst_pkg::mvst_token_type  new_tok;
   mvst_pkg::mvst_token_type  tok_chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0]    live;
   logic [TABLE_DEPTH-1:0]    load_en;
   logic                      conv_start;
   logic                      conv_done;
   mvst_pkg::mvst_result_type conv_res;
   logic                      wb_en;

   // Request decode.
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_load   = (req_chan.operation == mvst_pkg::OP_LOAD);
   assign is_lookup = !is_load && (req_chan.operation != mvst_pkg::OP_UNUSED);
   assign is_mic    = (req_chan.operation == mvst_pkg::OP_WRITE_MIC) ||
                      (req_chan.operation == mvst_pkg::OP_READ_MIC);
   assign has_room  = (count_ff < CNT_W'(TABLE_DEPTH));
   assign do_load   = accept && is_load && (req_chan.scale_bits != 3'd0) && has_room;

   always_comb begin
      load_entry.codec    = req_chan.codec;
      load_entry.reg_addr = req_chan.reg_addr;
      load_entry.scale    = req_chan.scale_bits;
      load_entry.invert   = req_chan.invert_flag;
      load_entry.value    = req_chan.load_value;

      load_res          = '0;
      load_res.found    = (req_chan.scale_bits != 3'd0) && has_room;
      load_res.table_full = (req_chan.scale_bits != 3'd0) && !has_room;

      // New search item enters the first cell on acceptance.
      new_tok          = '0;
      new_tok.active   = accept && is_lookup;
      new_tok.codec    = req_chan.codec;
      new_tok.reg_addr = is_mic ? mvst_pkg::MIC_REG : req_chan.reg_addr;
   end

   assign tok_chain[0] = new_tok;

   // Row of entry cells.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign live[i]    = (count_ff > CNT_W'(i));
      assign load_en[i] = do_load && (count_ff == CNT_W'(i));

      mvst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .live       (live[i]),
         .load_en    (load_en[i]),
         .load_entry (load_entry),
         .wb_en      (wb_en),
         .wb_value   (conv_res.write_value),
         .tok_in     (tok_chain[i]),
         .tok_out    (tok_chain[i+1])
      );
   end

   // Conversion of the item leaving the last cell.
   assign conv_start = (state_ff == ST_SCAN) && tok_chain[TABLE_DEPTH].active;
   assign wb_en      = (state_ff == ST_CONV) && conv_done && conv_res.write_valid;

   mvst_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .start       (conv_start),
      .tok         (tok_chain[TABLE_DEPTH]),
      .operation   (op_ff),
      .left_level  (left_ff),
      .right_level (right_ff),
      .done        (conv_done),
      .result      (conv_res)
   );

   // The output register takes a new result when it is empty or being drained.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer, entry count and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= req_chan.operation;
                  left_ff  <= req_chan.left_level;
                  right_ff <= req_chan.right_level;
                  if (is_load) begin
                     res_ff   <= load_res;
                     state_ff <= ST_DONE;
                     if (do_load) begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end else if (is_lookup) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     res_ff   <= '0;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SCAN: begin
               if (tok_chain[TABLE_DEPTH].active) begin
                  state_ff <= ST_CONV;
               end
            end
            ST_CONV: begin
               if (conv_done) begin
                  res_ff   <= conv_res;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Channel outputs.
   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = rsp_ff.found;
   assign rsp_chan.left_percent  = rsp_ff.left_percent;
   assign rsp_chan.right_percent = rsp_ff.right_percent;
   assign rsp_chan.write_valid   = rsp_ff.write_valid;
   assign rsp_chan.write_codec   = rsp_ff.write_codec;
   assign rsp_chan.write_reg     = rsp_ff.write_reg;
   assign rsp_chan.write_value   = rsp_ff.write_value;
   assign rsp_chan.table_full    = rsp_ff.table_full;

endmodule

[hdl/mvst_cell.sv]
// ----------------------------------------------------------------------------
// Mixer volume shadow table cell
// Holds one table entry, compares it against the passing search item and
// hands the item on to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module mvst_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     live,
   input  logic                     load_en,
   input  mvst_pkg::mvst_entry_type load_entry,
   input  logic                     wb_en,
   input  logic [15:0]              wb_value,
   input  mvst_pkg::mvst_token_type tok_in,
   output mvst_pkg::mvst_token_type tok_out
);

   mvst_pkg::mvst_entry_type entry_ff;
   mvst_pkg::mvst_token_type tok_ff;
   mvst_pkg::mvst_token_type tok_in_w;
   logic                     claimed_ff;
   logic                     match;

   // The first live entry that matches claims the item.
   assign match = tok_in.active && !tok_in.hit && live &&
                  (entry_ff.codec == tok_in.codec) &&
                  (entry_ff.reg_addr == tok_in.reg_addr);

   always_comb begin
      tok_in_w = tok_in;
      if (match) begin
         tok_in_w.hit    = 1'b1;
         tok_in_w.scale  = entry_ff.scale;
         tok_in_w.invert = entry_ff.invert;
         tok_in_w.value  = entry_ff.value;
      end
   end

   // Item stage and claim flag; the claim is renewed each time an item passes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
         claimed_ff    <= 1'b0;
      end else begin
         tok_ff <= tok_in_w;
         if (tok_in.active) begin
            claimed_ff <= match;
         end
      end
   end

   // Entry storage: loads fill it, write-backs update the claimed value.
   always_ff @(posedge clock) begin
      if (load_en) begin
         entry_ff <= load_entry;
      end else if (wb_en && claimed_ff) begin
         entry_ff.value <= wb_value;
      end
   end

   assign tok_out = tok_ff;

endmodule

[hdl/mvst_conv.sv]
// ----------------------------------------------------------------------------
// Mixer volume shadow table converter
// Two-stage unit that turns percent levels into fields for writes and
// stored fields back into percent for reads.
// ----------------------------------------------------------------------------
module mvst_conv (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  mvst_pkg::mvst_token_type  tok,
   input  logic [2:0]                operation,
   input  logic [6:0]                left_level,
   input  logic [6:0]                right_level,
   output logic                      done,
   output mvst_pkg::mvst_result_type result
);

   // Clamp a quotient to 0..100, inverting when asked.
   function automatic logic [6:0] to_pct(input logic [22:0] q, input logic inv);
      logic [6:0] r;
      if (inv) begin
         r = (q >= 23'(mvst_pkg::LEVEL_MAX)) ? 7'd0 : mvst_pkg::LEVEL_MAX - q[6:0];
      end else begin
         r = (q > 23'(mvst_pkg::LEVEL_MAX)) ? mvst_pkg::LEVEL_MAX : q[6:0];
      end
      return r;
   endfunction

   // Stage A signals.
   logic                     is_mic;
   logic                     inv;
   logic [6:0]               lp;
   logic [6:0]               rp;
   logic [6:0]               pl;
   logic [6:0]               pr;
   logic [15:0]              rl_field;
   logic                     valid_a_ff;
   logic [2:0]               op_a_ff;
   mvst_pkg::mvst_token_type tok_a_ff;
   logic                     inv_a_ff;
   logic                     lzero_a_ff;
   logic                     rzero_a_ff;
   logic [19:0]              wl_a_ff;
   logic [19:0]              wr_a_ff;
   logic [22:0]              rl_a_ff;
   logic [14:0]              rr_a_ff;

   // Stage B signals.
   logic [4:0]                shift_amt;
   logic [7:0]                scale;
   logic [7:0]                fl_raw;
   logic [7:0]                fr_raw;
   logic [7:0]                fl;
   logic [7:0]                fr;
   logic                      is_write;
   logic [15:0]               wval;
   mvst_pkg::mvst_result_type res_in;
   mvst_pkg::mvst_result_type res_ff;
   logic                      done_ff;

   // Level saturation and operand selection.
   always_comb begin
      is_mic = (operation == mvst_pkg::OP_WRITE_MIC) || (operation == mvst_pkg::OP_READ_MIC);
      inv    = tok.invert || is_mic;
      lp     = (left_level > mvst_pkg::LEVEL_MAX) ? mvst_pkg::LEVEL_MAX : left_level;
      rp     = (right_level > mvst_pkg::LEVEL_MAX) ? mvst_pkg::LEVEL_MAX : right_level;
      pl     = inv ? mvst_pkg::LEVEL_MAX - lp : lp;
      pr     = inv ? mvst_pkg::LEVEL_MAX - rp : rp;
      case (operation)
         mvst_pkg::OP_READ_STEREO: rl_field = {8'd0, tok.value[15:8]};
         mvst_pkg::OP_READ_MIC:    rl_field = tok.value & mvst_pkg::MIC_FIELD_MASK;
         default:                  rl_field = tok.value;
      endcase
   end

   // Stage A: products.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_a_ff    <= operation;
         tok_a_ff   <= tok;
         inv_a_ff   <= inv;
         lzero_a_ff <= (lp == 7'd0);
         rzero_a_ff <= (rp == 7'd0);
         wl_a_ff    <= 20'(pl) * 20'(mvst_pkg::RECIP_100);
         wr_a_ff    <= 20'(pr) * 20'(mvst_pkg::RECIP_100);
         rl_a_ff    <= 23'(rl_field) * 23'(mvst_pkg::LEVEL_MAX);
         rr_a_ff    <= 15'(tok.value & mvst_pkg::BYTE_MASK) * 15'(mvst_pkg::LEVEL_MAX);
      end
   end

   // Stage B: scaling, saturation and packing.
   always_comb begin
      shift_amt = mvst_pkg::RECIP_SHIFT - 5'(tok_a_ff.scale);
      scale     = 8'd1 << tok_a_ff.scale;
      fl_raw    = 8'(wl_a_ff >> shift_amt);
      fr_raw    = 8'(wr_a_ff >> shift_amt);
      fl        = (fl_raw >= scale) ? scale - 8'd1 : fl_raw;
      fr        = (fr_raw >= scale) ? scale - 8'd1 : fr_raw;
      is_write  = (op_a_ff == mvst_pkg::OP_WRITE_STEREO) ||
                  (op_a_ff == mvst_pkg::OP_WRITE_MONO) ||
                  (op_a_ff == mvst_pkg::OP_WRITE_MIC);

      case (op_a_ff)
         mvst_pkg::OP_WRITE_STEREO:
            wval = (lzero_a_ff && rzero_a_ff) ? mvst_pkg::MUTE_VALUE : {fl, fr};
         mvst_pkg::OP_WRITE_MIC:
            wval = lzero_a_ff ? mvst_pkg::MUTE_VALUE :
                   ((tok_a_ff.value & ~mvst_pkg::MIC_MASK) | 16'(fl));
         default:
            wval = lzero_a_ff ? mvst_pkg::MUTE_VALUE : 16'(fl);
      endcase

      res_in = '0;
      if (tok_a_ff.hit) begin
         res_in.found = 1'b1;
         if (is_write) begin
            res_in.write_valid = 1'b1;
            res_in.write_codec = tok_a_ff.codec;
            res_in.write_reg   = tok_a_ff.reg_addr;
            res_in.write_value = wval;
         end else begin
            case (op_a_ff)
               mvst_pkg::OP_READ_STEREO: begin
                  if (tok_a_ff.value != mvst_pkg::MUTE_VALUE) begin
                     res_in.left_percent  = to_pct(rl_a_ff >> tok_a_ff.scale, inv_a_ff);
                     res_in.right_percent = to_pct(23'(rr_a_ff >> tok_a_ff.scale), inv_a_ff);
                  end
               end
               mvst_pkg::OP_READ_MIC: begin
                  if ((tok_a_ff.value & mvst_pkg::MIC_MASK) != mvst_pkg::MUTE_VALUE) begin
                     res_in.left_percent = to_pct(rl_a_ff >> tok_a_ff.scale, inv_a_ff);
                  end
               end
               default: begin
                  if (tok_a_ff.value != mvst_pkg::MUTE_VALUE) begin
                     res_in.left_percent = to_pct(rl_a_ff >> tok_a_ff.scale, inv_a_ff);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_a_ff) begin
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[dv/mixer_volume_shadow_table_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mixer volume shadow table testbench
// Drives load, write and read items into the shadow table and checks every
// result item against a cycle-free predictor of the table kept in the bench.
// A directed opening covers misses, dropped loads, first-match lookups, mute
// values and clamping; random items follow under several idling patterns,
// including one long output hold that backs the block up.
// ----------------------------------------------------------------------------
module mixer_volume_shadow_table_top_tb;

   localparam int TABLE_ENTRIES  = 16;
   localparam int ITEMS_PER_PASS = 275;
   localparam int STALL_HOLD     = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;

   // One request item as the bench sees it.
   typedef struct packed {
      logic [2:0]  operation;
      logic [1:0]  codec;
      logic [6:0]  reg_addr;
      logic [6:0]  left_level;
      logic [6:0]  right_level;
      logic [2:0]  scale_bits;
      logic        invert_flag;
      logic [15:0] load_value;
   } mixer_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mvst_req_if req_chan ();
   mvst_rsp_if rsp_chan ();

   mixer_volume_shadow_table_top #(
      .TABLE_DEPTH (TABLE_ENTRIES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Items waiting to be offered and results waiting to arrive.
   mixer_cmd_type             pending_items[$];
   mvst_pkg::mvst_result_type expected_results[$];

   // Bench copy of the shadow table, advanced once per accepted item.
   logic [1:0]  shadow_codec  [TABLE_ENTRIES];
   logic [6:0]  shadow_reg    [TABLE_ENTRIES];
   logic [2:0]  shadow_scale  [TABLE_ENTRIES];
   logic        shadow_invert [TABLE_ENTRIES];
   logic [15:0] shadow_value  [TABLE_ENTRIES];
   int          shadow_count = 0;

   // Keys the stimulus has stored so far, used to aim lookups at real entries.
   logic [1:0]  known_codec[$];
   logic [6:0]  known_reg[$];
   logic [1:0]  known_mic_codec[$];
   int          known_stored = 0;

   // Idling controls and the long output hold.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int stall_requests     = 0;
   int stall_served       = 0;
   int hold_left          = 0;
   int quiet_cycles       = 0;
   int mismatches         = 0;

   mixer_cmd_type offered;

   // Clip a percent level to 100.
   function automatic int level_clip(input logic [6:0] level);
      return (level > mvst_pkg::LEVEL_MAX) ? int'(mvst_pkg::LEVEL_MAX) : int'(level);
   endfunction

   // Percent to attenuation field, saturated to scale minus one.
   function automatic int level_to_field(input int pct, input int scale, input logic inv);
      int f;
      f = inv ? ((100 - pct) * scale) / 100 : (pct * scale) / 100;
      if (f >= scale) f = scale - 1;
      return f;
   endfunction

   // Attenuation field back to a percent level, clamped to 0..100.
   function automatic int field_to_level(input int field, input int scale, input logic inv);
      int q;
      q = (field * 100) / scale;
      if (inv) return (q >= 100) ? 0 : 100 - q;
      return (q > 100) ? 100 : q;
   endfunction

   // Work out the result of one accepted item and update the bench table.
   function automatic mvst_pkg::mvst_result_type predict_result(input mixer_cmd_type cmd);
      mvst_pkg::mvst_result_type res;
      int                        hit;
      int                        idx;
      int                        scale;
      int                        lp;
      int                        rp;
      logic                      inv;
      logic                      is_write;
      logic [6:0]                target;
      logic [15:0]               v;
      res      = '0;
      hit      = -1;
      is_write = 1'b0;
      lp       = level_clip(cmd.left_level);
      rp       = level_clip(cmd.right_level);
      if (cmd.operation == mvst_pkg::OP_LOAD) begin
         // Scale zero drops the entry before the fullness check.
         if (cmd.scale_bits != 3'd0) begin
            if (shadow_count >= TABLE_ENTRIES) begin
               res.table_full = 1'b1;
            end else begin
               shadow_codec[shadow_count]  = cmd.codec;
               shadow_reg[shadow_count]    = cmd.reg_addr;
               shadow_scale[shadow_count]  = cmd.scale_bits;
               shadow_invert[shadow_count] = cmd.invert_flag;
               shadow_value[shadow_count]  = cmd.load_value;
               shadow_count++;
               res.found = 1'b1;
            end
         end
      end else if (cmd.operation != mvst_pkg::OP_UNUSED) begin
         target = (cmd.operation == mvst_pkg::OP_WRITE_MIC ||
                   cmd.operation == mvst_pkg::OP_READ_MIC) ? mvst_pkg::MIC_REG : cmd.reg_addr;
         // First match wins.
         for (idx = shadow_count - 1; idx >= 0; idx--) begin
            if (shadow_codec[idx] == cmd.codec && shadow_reg[idx] == target) hit = idx;
         end
         if (hit >= 0) begin
            scale     = 1 << shadow_scale[hit];
            inv       = shadow_invert[hit];
            v         = shadow_value[hit];
            res.found = 1'b1;
            case (cmd.operation)
               mvst_pkg::OP_WRITE_STEREO: begin
                  is_write = 1'b1;
                  if (lp == 0 && rp == 0) v = mvst_pkg::MUTE_VALUE;
                  else v = 16'((level_to_field(lp, scale, inv) << 8) |
                               level_to_field(rp, scale, inv));
               end
               mvst_pkg::OP_WRITE_MONO: begin
                  is_write = 1'b1;
                  v = (lp == 0) ? mvst_pkg::MUTE_VALUE : 16'(level_to_field(lp, scale, inv));
               end
               mvst_pkg::OP_WRITE_MIC: begin
                  is_write = 1'b1;
                  if (lp == 0) v = mvst_pkg::MUTE_VALUE;
                  else v = (v & ~mvst_pkg::MIC_MASK) | 16'(level_to_field(lp, scale, 1'b1));
               end
               mvst_pkg::OP_READ_STEREO: begin
                  if (v != mvst_pkg::MUTE_VALUE) begin
                     res.left_percent  = 7'(field_to_level(int'(v >> 8), scale, inv));
                     res.right_percent = 7'(field_to_level(int'(v & mvst_pkg::BYTE_MASK),
                                                           scale, inv));
                  end
               end
               mvst_pkg::OP_READ_MONO: begin
                  if (v != mvst_pkg::MUTE_VALUE)
                     res.left_percent = 7'(field_to_level(int'(v), scale, inv));
               end
               default: begin
                  if ((v & mvst_pkg::MIC_MASK) != mvst_pkg::MUTE_VALUE)
                     res.left_percent = 7'(field_to_level(int'(v & mvst_pkg::MIC_FIELD_MASK),
                                                          scale, 1'b1));
               end
            endcase
            if (is_write) begin
               shadow_value[hit] = v;
               res.write_valid   = 1'b1;
               res.write_codec   = cmd.codec;
               res.write_reg     = target;
               res.write_value   = v;
            end
         end
      end
      return res;
   endfunction

   // Track which keys the stimulus has stored, in the order they are sent.
   function automatic void note_load(input mixer_cmd_type cmd);
      if (cmd.scale_bits != 3'd0 && known_stored < TABLE_ENTRIES) begin
         known_codec = {known_codec, cmd.codec};
         known_reg   = {known_reg, cmd.reg_addr};
         if (cmd.reg_addr == mvst_pkg::MIC_REG) known_mic_codec = {known_mic_codec, cmd.codec};
         known_stored++;
      end
   endfunction

   // Append one item to the tail of the pending queue.
   function automatic void queue_item(input mixer_cmd_type cmd);
      pending_items = {pending_items, cmd};
   endfunction

   function automatic mixer_cmd_type load_cmd(input logic [1:0] codec, input logic [6:0] addr,
                                              input logic [2:0] scale, input logic inv,
                                              input logic [15:0] value);
      mixer_cmd_type cmd;
      cmd.operation   = mvst_pkg::OP_LOAD;
      cmd.codec       = codec;
      cmd.reg_addr    = addr;
      cmd.left_level  = 7'($urandom);
      cmd.right_level = 7'($urandom);
      cmd.scale_bits  = scale;
      cmd.invert_flag = inv;
      cmd.load_value  = value;
      note_load(cmd);
      return cmd;
   endfunction

   // Lookup item; the fields a lookup ignores carry random bits.
   function automatic mixer_cmd_type lookup_cmd(input logic [2:0] op, input logic [1:0] codec,
                                                input logic [6:0] addr, input logic [6:0] left,
                                                input logic [6:0] right);
      mixer_cmd_type cmd;
      cmd.operation   = op;
      cmd.codec       = codec;
      cmd.reg_addr    = addr;
      cmd.left_level  = left;
      cmd.right_level = right;
      cmd.scale_bits  = 3'($urandom);
      cmd.invert_flag = 1'($urandom);
      cmd.load_value  = 16'($urandom);
      return cmd;
   endfunction

   // Levels lean on mute, full scale and the saturating range above 100.
   function automatic logic [6:0] pick_level();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) return 7'd0;
      if (roll < 30) return mvst_pkg::LEVEL_MAX;
      if (roll < 40) return 7'($urandom_range(101, 127));
      return 7'($urandom_range(0, 100));
   endfunction

   // Random item: mostly lookups aimed at stored keys, some loads and noise.
   function automatic mixer_cmd_type random_item();
      mixer_cmd_type cmd;
      int            roll;
      int            k;
      logic          is_mic;
      cmd  = lookup_cmd(mvst_pkg::OP_UNUSED, 2'($urandom), 7'($urandom), pick_level(),
                        pick_level());
      roll = $urandom_range(99);
      if (roll < 8) begin
         if ($urandom_range(2) == 0) cmd.reg_addr = mvst_pkg::MIC_REG;
         cmd = load_cmd(cmd.codec, cmd.reg_addr, cmd.scale_bits, cmd.invert_flag,
                        cmd.load_value);
      end else if (roll >= 10) begin
         cmd.operation = 3'($urandom_range(mvst_pkg::OP_WRITE_STEREO, mvst_pkg::OP_READ_MIC));
         is_mic = (cmd.operation == mvst_pkg::OP_WRITE_MIC ||
                   cmd.operation == mvst_pkg::OP_READ_MIC);
         if ($urandom_range(99) < 85) begin
            if (is_mic && known_mic_codec.size() != 0) begin
               cmd.codec = known_mic_codec[$urandom_range(known_mic_codec.size() - 1)];
            end else if (!is_mic && known_codec.size() != 0) begin
               k = $urandom_range(known_codec.size() - 1);
               cmd.codec    = known_codec[k];
               cmd.reg_addr = known_reg[k];
            end
         end
      end
      return cmd;
   endfunction

   // Report one field that differs from its expectation.
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Driver: offers pending items and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results = {expected_results, predict_result(offered)};
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered = pending_items.pop_front();
               req_chan.operation   <= offered.operation;
               req_chan.codec       <= offered.codec;
               req_chan.reg_addr    <= offered.reg_addr;
               req_chan.left_level  <= offered.left_level;
               req_chan.right_level <= offered.right_level;
               req_chan.scale_bits  <= offered.scale_bits;
               req_chan.invert_flag <= offered.invert_flag;
               req_chan.load_value  <= offered.load_value;
               req_chan.valid       <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result and paces the ready signal.
   always @(posedge clock) begin : result_monitor
      mvst_pkg::mvst_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("result item arrived with nothing expected");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("found", 16'(want.found), 16'(rsp_chan.found));
               check_field("left_percent", 16'(want.left_percent), 16'(rsp_chan.left_percent));
               check_field("right_percent", 16'(want.right_percent),
                           16'(rsp_chan.right_percent));
               check_field("write_valid", 16'(want.write_valid), 16'(rsp_chan.write_valid));
               check_field("write_codec", 16'(want.write_codec), 16'(rsp_chan.write_codec));
               check_field("write_reg", 16'(want.write_reg), 16'(rsp_chan.write_reg));
               check_field("write_value", want.write_value, rsp_chan.write_value);
               check_field("table_full", 16'(want.table_full), 16'(rsp_chan.table_full));
            end
         end
         // A requested hold keeps ready low for a long stretch.
         if (stall_served != stall_requests) begin
            stall_served   <= stall_served + 1;
            hold_left      <= STALL_HOLD;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed opening, then random passes under changing idling.
   initial begin : stimulus
      int pass;
      int n;
      req_chan.valid       = 1'b0;
      req_chan.operation   = mvst_pkg::OP_LOAD;
      req_chan.codec       = '0;
      req_chan.reg_addr    = '0;
      req_chan.left_level  = '0;
      req_chan.right_level = '0;
      req_chan.scale_bits  = '0;
      req_chan.invert_flag = 1'b0;
      req_chan.load_value  = '0;
      rsp_chan.ready       = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Lookups into an empty table miss, and a scale zero load is dropped.
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_STEREO, 2'd0, 7'd0, 7'd50, 7'd50));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_MIC, 2'd1, 7'd0, 7'd0, 7'd0));
      queue_item(load_cmd(2'd3, 7'h7F, 3'd0, 1'b1, 16'hFFFF));
      // Entries at the field extremes; the last one is shadowed by the first.
      queue_item(load_cmd(2'd0, 7'h00, 3'd7, 1'b0, 16'h0000));
      queue_item(load_cmd(2'd3, 7'h7F, 3'd5, 1'b1, 16'hFFFF));
      queue_item(load_cmd(2'd1, mvst_pkg::MIC_REG, 3'd5, 1'b0, 16'hFFFF));
      queue_item(load_cmd(2'd2, 7'h55, 3'd1, 1'b0, mvst_pkg::MUTE_VALUE));
      queue_item(load_cmd(2'd0, 7'h00, 3'd3, 1'b1, 16'h1234));
      // Reads of loaded values, clamped high and low.
      queue_item(lookup_cmd(mvst_pkg::OP_READ_STEREO, 2'd0, 7'h00, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_STEREO, 2'd1, mvst_pkg::MIC_REG, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_MONO, 2'd3, 7'h7F, 7'd0, 7'd0));
      // Stereo with saturated levels, then stereo mute.
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_STEREO, 2'd0, 7'h00, mvst_pkg::LEVEL_MAX,
                            7'd127));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_STEREO, 2'd0, 7'h00, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_STEREO, 2'd0, 7'h00, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_STEREO, 2'd0, 7'h00, 7'd0, 7'd0));
      // Mono mute and full scale on an inverted entry, then a loaded mute value.
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_MONO, 2'd3, 7'h7F, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_MONO, 2'd3, 7'h7F, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_MONO, 2'd3, 7'h7F, mvst_pkg::LEVEL_MAX, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_MONO, 2'd3, 7'h7F, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_MONO, 2'd2, 7'h55, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_MONO, 2'd2, 7'h55, 7'd50, 7'd0));
      // Mic ignores the register field and keeps the bits outside its mask.
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_MIC, 2'd1, 7'h2A, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_MIC, 2'd1, 7'h11, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_MIC, 2'd1, 7'h00, 7'd127, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_WRITE_MIC, 2'd1, 7'h00, 7'd1, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_READ_MIC, 2'd1, 7'h00, 7'd0, 7'd0));
      queue_item(lookup_cmd(mvst_pkg::OP_UNUSED, 2'd3, 7'h7F, mvst_pkg::LEVEL_MAX,
                            mvst_pkg::LEVEL_MAX));
      while (pending_items.size() != 0) @(posedge clock);

      // Random passes: no idling with one long hold, sender idle, receiver
      // stalling, then both.
      for (pass = 0; pass < 4; pass++) begin
         @(posedge clock);
         case (pass)
            0: begin
               sender_idle_pct    <= 0;
               receiver_stall_pct <= 0;
               stall_requests     <= stall_requests + 1;
            end
            1: begin
               sender_idle_pct    <= 88;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct    <= 0;
               receiver_stall_pct <= 88;
            end
            default: begin
               sender_idle_pct    <= 28;
               receiver_stall_pct <= 28;
            end
         endcase
         for (n = 0; n < ITEMS_PER_PASS; n++) queue_item(random_item());
         while (pending_items.size() != 0) @(posedge clock);
      end

      // Drain everything still in flight.
      while (pending_items.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
